FILE: hdl/cpir_pkg.sv
// ============================================================================
// cpir_pkg
// Shared types, widths and helpers of the circle pair impulse resolver.
// ============================================================================
`default_nettype none

package cpir_pkg;

  localparam int F     = 16;            // fraction bits of positions and masses
  localparam int QW    = F + 1;         // normal and mass ratio magnitude
  localparam int NW    = QW + 1;        // signed normal component
  localparam int PENW  = 33;            // penetration depth
  localparam int PW    = QW + PENW - F; // depth along one axis
  localparam int SAW   = PW + QW - F;   // position shift
  localparam int RELW  = 33;            // relative velocity
  localparam int PVW   = RELW + NW;     // one term of the normal speed
  localparam int VW    = PVW + 1;       // normal speed, 2F fraction bits
  localparam int SW    = VW - F;        // normal speed magnitude
  localparam int RB    = 16;            // restitution fraction bits
  localparam int EW    = 17;            // restitution width
  localparam int JW    = SW + EW + 1 - RB;
  localparam int DW    = JW + QW - F;   // velocity change per circle
  localparam int AW    = DW + QW - F;   // velocity change per axis
  localparam int MAGW  = 48;            // magnitude width of apply_sat

  localparam int QD    = 4;             // front to back queue depth
  localparam int QAW   = 2;
  localparam int QCW   = 3;

  localparam int SQ_STEPS = 32;

  localparam logic [EW-1:0] RES_RESET = 17'd52429;
  localparam logic [EW-1:0] RES_ONE   = 17'h10000;
  localparam logic [QW-1:0] N_ONE     = QW'(1) << F;
  localparam logic [QW-1:0] HALF      = QW'(1) << (F - 1);

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] avx;
    logic signed [31:0] avy;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bvx;
    logic signed [31:0] bvy;
  } kin_t;

  typedef struct packed {
    kin_t        k;
    logic        ov;
    logic        dxs;
    logic        dys;
    logic [31:0] dxm;
    logic [31:0] dym;
    logic [31:0] rsum;
    logic [31:0] tot;
    logic [30:0] ma;
    logic [30:0] mb;
    logic [63:0] lo;
  } fr_t;

  typedef struct packed {
    fr_t           f;
    logic [31:0]   sep;
    logic [QW-1:0] nxq;
    logic [QW-1:0] nyq;
    logic [QW-1:0] raq;
    logic [QW-1:0] rbq;
  } sv_t;

  typedef struct packed {
    logic signed [31:0] pax;
    logic signed [31:0] pay;
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] pbx;
    logic signed [31:0] pby;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    logic               ov;
    logic               imp;
  } out_t;

  typedef struct packed {
    logic full;
    logic nempty;
  } q_stat_t;

  // base minus (or plus) sign(n) * m, saturated to 32 bit signed
  function automatic logic signed [31:0] apply_sat(input logic signed [31:0] base,
                                                   input logic neg,
                                                   input logic [MAGW-1:0] m,
                                                   input logic add);
    logic signed [MAGW+1:0] d;
    logic signed [MAGW+1:0] r;
    logic signed [31:0]     q;
    d = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
    r = add ? (MAGW+2)'(base) + d : (MAGW+2)'(base) - d;
    if ((&r[MAGW+1:31]) || !(|r[MAGW+1:31])) begin
      q = r[31:0];
    end else if (r[MAGW+1]) begin
      q = 32'sh80000000;
    end else begin
      q = 32'sh7fffffff;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/cpir_front.sv
// ============================================================================
// cpir_front
// Accepts pairs, forms centre offsets and squares, decides overlap.
// ============================================================================
`default_nettype none

module cpir_front import cpir_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               q_full,
  input  logic signed [31:0] a_pos_x,
  input  logic signed [31:0] a_pos_y,
  input  logic signed [31:0] a_vel_x,
  input  logic signed [31:0] a_vel_y,
  input  logic        [30:0] a_radius,
  input  logic        [30:0] a_mass,
  input  logic signed [31:0] b_pos_x,
  input  logic signed [31:0] b_pos_y,
  input  logic signed [31:0] b_vel_x,
  input  logic signed [31:0] b_vel_y,
  input  logic        [30:0] b_radius,
  input  logic        [30:0] b_mass,
  output logic               wr,
  output fr_t                wr_d
);

  typedef struct packed {
    kin_t        k;
    logic        dxs;
    logic        dys;
    logic [31:0] dxm;
    logic [31:0] dym;
    logic [31:0] rsum;
    logic [31:0] tot;
    logic [30:0] ma;
    logic [30:0] mb;
  } f1_t;

  typedef struct packed {
    f1_t         b;
    logic [63:0] sx;
    logic [63:0] sy;
    logic [63:0] rsq;
  } f2_t;

  logic               en;
  logic               v1, v2;
  f1_t                s1, s1_next;
  f2_t                s2, s2_next;
  logic signed [32:0] dx, dy;
  logic        [64:0] lo;

  assign en = !q_full;

  always_comb begin
    dx = 33'(b_pos_x) - 33'(a_pos_x);
    dy = 33'(b_pos_y) - 33'(a_pos_y);
    s1_next.k    = '{a_pos_x, a_pos_y, a_vel_x, a_vel_y,
                     b_pos_x, b_pos_y, b_vel_x, b_vel_y};
    s1_next.dxs  = dx[32];
    s1_next.dys  = dy[32];
    s1_next.dxm  = dx[32] ? 32'(-dx) : dx[31:0];
    s1_next.dym  = dy[32] ? 32'(-dy) : dy[31:0];
    s1_next.rsum = 32'(a_radius) + 32'(b_radius);
    s1_next.tot  = 32'(a_mass) + 32'(b_mass);
    s1_next.ma   = a_mass;
    s1_next.mb   = b_mass;
  end

  always_comb begin
    s2_next.b   = s1;
    s2_next.sx  = 64'(s1.dxm) * 64'(s1.dxm);
    s2_next.sy  = 64'(s1.dym) * 64'(s1.dym);
    s2_next.rsq = 64'(s1.rsum) * 64'(s1.rsum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= push;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
      s2 <= s2_next;
    end
  end

  always_comb begin
    lo        = {1'b0, s2.sx} + {1'b0, s2.sy};
    wr        = v2 && en;
    wr_d.k    = s2.b.k;
    wr_d.ov   = !lo[64] && (lo[63:0] < s2.rsq);
    wr_d.dxs  = s2.b.dxs;
    wr_d.dys  = s2.b.dys;
    wr_d.dxm  = s2.b.dxm;
    wr_d.dym  = s2.b.dym;
    wr_d.rsum = s2.b.rsum;
    wr_d.tot  = s2.b.tot;
    wr_d.ma   = s2.b.ma;
    wr_d.mb   = s2.b.mb;
    wr_d.lo   = lo[63:0];
  end

endmodule

`default_nettype wire

FILE: hdl/cpir_queue.sv
// ============================================================================
// cpir_queue
// Short queue between the classifying front and the arithmetic back.
// ============================================================================
`default_nettype none

module cpir_queue import cpir_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr,
  input  fr_t     wr_d,
  input  logic    rd,
  output fr_t     rd_d,
  output q_stat_t st
);

  fr_t            mem [QD];
  logic [QAW-1:0] wptr, rptr;
  logic [QCW-1:0] cnt;

  assign st.full   = (cnt == QCW'(QD));
  assign st.nempty = (cnt != '0);
  assign rd_d      = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      if (wr && !rd) cnt <= cnt + 1'b1;
      else if (rd && !wr) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wr_d;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= QCW'(QD))
    else $error("queue count above depth");
  a_cnt_up: assert property (@(posedge clk) disable iff (rst)
      (wr && !rd) |=> (cnt == $past(cnt) + 1'b1))
    else $error("queue count missed a write");

endmodule

`default_nettype wire

FILE: hdl/cpir_solve.sv
// ============================================================================
// cpir_solve
// Pipelined integer square root of the squared distance, then four
// pipelined restoring dividers for the normal and the mass shares.
// ============================================================================
`default_nettype none

module cpir_solve import cpir_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_v,
  input  fr_t  in_d,
  output logic out_v,
  output sv_t  out_d
);

  typedef struct packed {
    fr_t         f;
    logic [63:0] rem;
    logic [63:0] res;
  } sq_t;

  typedef struct packed {
    fr_t                  f;
    logic [31:0]          sep;
    logic [3:0][32:0]     r;
    logic [3:0][QW-1:0]   q;
  } dv_t;

  sq_t  sq  [1:SQ_STEPS];
  logic sqv [1:SQ_STEPS];
  dv_t  dv  [1:QW];
  logic dvv [1:QW];
  sq_t  sq_in;
  dv_t  dv_in;

  always_comb begin
    sq_in.f   = in_d;
    sq_in.rem = in_d.lo;
    sq_in.res = '0;
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    localparam int SH = 62 - 2 * k;
    sq_t         cur, nxt;
    logic        cur_v;
    logic [64:0] t;
    if (k == 0) begin : g_first
      assign cur   = sq_in;
      assign cur_v = in_v;
    end else begin : g_rest
      assign cur   = sq[k];
      assign cur_v = sqv[k];
    end
    always_comb begin
      nxt = cur;
      t   = {1'b0, cur.res} + (65'd1 << SH);
      if ({1'b0, cur.rem} >= t) begin
        nxt.rem = cur.rem - t[63:0];
        nxt.res = (cur.res >> 1) + (64'd1 << SH);
      end else begin
        nxt.res = cur.res >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) sqv[k+1] <= 1'b0;
      else if (adv) sqv[k+1] <= cur_v;
    end
    always_ff @(posedge clk) begin
      if (adv) sq[k+1] <= nxt;
    end
  end

  always_comb begin
    dv_in.f    = sq[SQ_STEPS].f;
    dv_in.sep  = sq[SQ_STEPS].res[31:0];
    dv_in.r[0] = 33'(sq[SQ_STEPS].f.dxm);
    dv_in.r[1] = 33'(sq[SQ_STEPS].f.dym);
    dv_in.r[2] = 33'(sq[SQ_STEPS].f.mb);
    dv_in.r[3] = 33'(sq[SQ_STEPS].f.ma);
    dv_in.q    = '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_dv
    dv_t              cur, nxt;
    logic             cur_v;
    logic [3:0][32:0] den;
    logic [32:0]      rr;
    if (k == 0) begin : g_first
      assign cur   = dv_in;
      assign cur_v = sqv[SQ_STEPS];
    end else begin : g_rest
      assign cur   = dv[k];
      assign cur_v = dvv[k];
    end
    always_comb begin
      nxt    = cur;
      den[0] = 33'(cur.sep);
      den[1] = 33'(cur.sep);
      den[2] = 33'(cur.f.tot);
      den[3] = 33'(cur.f.tot);
      rr     = '0;
      for (int i = 0; i < 4; i++) begin
        if (cur.r[i] >= den[i]) begin
          rr        = cur.r[i] - den[i];
          nxt.q[i]  = {cur.q[i][QW-2:0], 1'b1};
        end else begin
          rr        = cur.r[i];
          nxt.q[i]  = {cur.q[i][QW-2:0], 1'b0};
        end
        nxt.r[i] = {rr[31:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) dvv[k+1] <= 1'b0;
      else if (adv) dvv[k+1] <= cur_v;
    end
    always_ff @(posedge clk) begin
      if (adv) dv[k+1] <= nxt;
    end
  end

  assign out_v       = dvv[QW];
  assign out_d.f     = dv[QW].f;
  assign out_d.sep   = dv[QW].sep;
  assign out_d.nxq   = dv[QW].q[0];
  assign out_d.nyq   = dv[QW].q[1];
  assign out_d.raq   = dv[QW].q[2];
  assign out_d.rbq   = dv[QW].q[3];

endmodule

`default_nettype wire

FILE: hdl/cpir_post.sv
// ============================================================================
// cpir_post
// Separation and impulse arithmetic, saturation and the result register.
// ============================================================================
`default_nettype none

module cpir_post import cpir_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic [EW-1:0] rest,
  input  logic          in_v,
  input  sv_t           in_d,
  output logic          out_v,
  output out_t          out_d
);

  typedef struct packed {
    kin_t                   k;
    logic                   ov, nxneg, nyneg;
    logic [QW-1:0]          nxm, nym, rata, ratb;
    logic [PENW-1:0]        pen;
    logic signed [RELW-1:0] relx, rely;
    logic signed [NW-1:0]   nxs, nys;
  } m1_t;

  typedef struct packed {
    kin_t                  k;
    logic                  ov, nxneg, nyneg;
    logic [QW-1:0]         nxm, nym, rata, ratb;
    logic [PW-1:0]         px, py;
    logic signed [PVW-1:0] pvx, pvy;
  } m2_t;

  typedef struct packed {
    kin_t                 k;
    logic                 ov, nxneg, nyneg;
    logic [QW-1:0]        nxm, nym, rata, ratb;
    logic [SAW-1:0]       sax, say, sbx, sby;
    logic signed [VW-1:0] vn;
  } m3_t;

  typedef struct packed {
    logic signed [31:0] pax, pay, pbx, pby, avx, avy, bvx, bvy;
    logic               ov, imp, nxneg, nyneg;
    logic [QW-1:0]      nxm, nym, rata, ratb;
    logic [SW-1:0]      s;
    logic [EW-1:0]      e;
  } m4_t;

  typedef struct packed {
    logic signed [31:0] pax, pay, pbx, pby, avx, avy, bvx, bvy;
    logic               ov, imp, nxneg, nyneg;
    logic [QW-1:0]      nxm, nym, rata, ratb;
    logic [JW-1:0]      j;
  } m5_t;

  typedef struct packed {
    logic signed [31:0] pax, pay, pbx, pby, avx, avy, bvx, bvy;
    logic               ov, imp, nxneg, nyneg;
    logic [QW-1:0]      nxm, nym;
    logic [DW-1:0]      dva, dvb;
  } m6_t;

  typedef struct packed {
    logic signed [31:0] pax, pay, pbx, pby, avx, avy, bvx, bvy;
    logic               ov, imp, nxneg, nyneg;
    logic [AW-1:0]      dax, day, dbx, dby;
  } m7_t;

  m1_t  m1, m1_next;
  m2_t  m2, m2_next;
  m3_t  m3, m3_next;
  m4_t  m4, m4_next;
  m5_t  m5, m5_next;
  m6_t  m6, m6_next;
  m7_t  m7, m7_next;
  out_t o_next;
  logic v1, v2, v3, v4, v5, v6, v7;

  logic                 nz, tz;
  logic [QW+PENW-1:0]   prx, pry;
  logic [PW+QW-1:0]     pr_ax, pr_ay, pr_bx, pr_by;
  logic signed [VW-1:0] nvn;
  logic [SW+EW:0]       pr_j;
  logic [JW+QW-1:0]     pr_a, pr_b;
  logic [DW+QW-1:0]     pr_vax, pr_vay, pr_vbx, pr_vby;

  always_comb begin
    nz = (in_d.sep == '0);
    tz = (in_d.f.tot == '0);
    m1_next.k     = in_d.f.k;
    m1_next.ov    = in_d.f.ov;
    m1_next.nxm   = nz ? N_ONE : in_d.nxq;
    m1_next.nym   = nz ? '0 : in_d.nyq;
    m1_next.nxneg = !nz && in_d.f.dxs && (in_d.nxq != '0);
    m1_next.nyneg = !nz && in_d.f.dys && (in_d.nyq != '0);
    m1_next.rata  = tz ? HALF : in_d.raq;
    m1_next.ratb  = tz ? HALF : in_d.rbq;
    m1_next.pen   = PENW'(in_d.f.rsum) - PENW'(in_d.sep);
    m1_next.relx  = RELW'(in_d.f.k.bvx) - RELW'(in_d.f.k.avx);
    m1_next.rely  = RELW'(in_d.f.k.bvy) - RELW'(in_d.f.k.avy);
    m1_next.nxs   = m1_next.nxneg ? -$signed({1'b0, m1_next.nxm}) : $signed({1'b0, m1_next.nxm});
    m1_next.nys   = m1_next.nyneg ? -$signed({1'b0, m1_next.nym}) : $signed({1'b0, m1_next.nym});
  end

  always_comb begin
    prx = (QW+PENW)'(m1.nxm) * (QW+PENW)'(m1.pen);
    pry = (QW+PENW)'(m1.nym) * (QW+PENW)'(m1.pen);
    m2_next.k     = m1.k;
    m2_next.ov    = m1.ov;
    m2_next.nxneg = m1.nxneg;
    m2_next.nyneg = m1.nyneg;
    m2_next.nxm   = m1.nxm;
    m2_next.nym   = m1.nym;
    m2_next.rata  = m1.rata;
    m2_next.ratb  = m1.ratb;
    m2_next.px    = prx[QW+PENW-1:F];
    m2_next.py    = pry[QW+PENW-1:F];
    m2_next.pvx   = PVW'(m1.relx) * PVW'(m1.nxs);
    m2_next.pvy   = PVW'(m1.rely) * PVW'(m1.nys);
  end

  always_comb begin
    pr_ax = (PW+QW)'(m2.px) * (PW+QW)'(m2.rata);
    pr_ay = (PW+QW)'(m2.py) * (PW+QW)'(m2.rata);
    pr_bx = (PW+QW)'(m2.px) * (PW+QW)'(m2.ratb);
    pr_by = (PW+QW)'(m2.py) * (PW+QW)'(m2.ratb);
    m3_next.k     = m2.k;
    m3_next.ov    = m2.ov;
    m3_next.nxneg = m2.nxneg;
    m3_next.nyneg = m2.nyneg;
    m3_next.nxm   = m2.nxm;
    m3_next.nym   = m2.nym;
    m3_next.rata  = m2.rata;
    m3_next.ratb  = m2.ratb;
    m3_next.sax   = pr_ax[PW+QW-1:F];
    m3_next.say   = pr_ay[PW+QW-1:F];
    m3_next.sbx   = pr_bx[PW+QW-1:F];
    m3_next.sby   = pr_by[PW+QW-1:F];
    m3_next.vn    = VW'(m2.pvx) + VW'(m2.pvy);
  end

  always_comb begin
    nvn = -m3.vn;
    m4_next.pax   = m3.ov ? apply_sat(m3.k.ax, m3.nxneg, MAGW'(m3.sax), 1'b0) : m3.k.ax;
    m4_next.pay   = m3.ov ? apply_sat(m3.k.ay, m3.nyneg, MAGW'(m3.say), 1'b0) : m3.k.ay;
    m4_next.pbx   = m3.ov ? apply_sat(m3.k.bx, m3.nxneg, MAGW'(m3.sbx), 1'b1) : m3.k.bx;
    m4_next.pby   = m3.ov ? apply_sat(m3.k.by, m3.nyneg, MAGW'(m3.sby), 1'b1) : m3.k.by;
    m4_next.avx   = m3.k.avx;
    m4_next.avy   = m3.k.avy;
    m4_next.bvx   = m3.k.bvx;
    m4_next.bvy   = m3.k.bvy;
    m4_next.ov    = m3.ov;
    m4_next.imp   = m3.ov && (m3.vn[VW-1] || (m3.vn == '0));
    m4_next.nxneg = m3.nxneg;
    m4_next.nyneg = m3.nyneg;
    m4_next.nxm   = m3.nxm;
    m4_next.nym   = m3.nym;
    m4_next.rata  = m3.rata;
    m4_next.ratb  = m3.ratb;
    m4_next.s     = nvn[VW-1:F];
    m4_next.e     = (rest > RES_ONE) ? RES_ONE : rest;
  end

  always_comb begin
    pr_j = (SW+EW+1)'(m4.s) * ((SW+EW+1)'(m4.e) + (SW+EW+1)'(RES_ONE));
    m5_next.pax   = m4.pax;
    m5_next.pay   = m4.pay;
    m5_next.pbx   = m4.pbx;
    m5_next.pby   = m4.pby;
    m5_next.avx   = m4.avx;
    m5_next.avy   = m4.avy;
    m5_next.bvx   = m4.bvx;
    m5_next.bvy   = m4.bvy;
    m5_next.ov    = m4.ov;
    m5_next.imp   = m4.imp;
    m5_next.nxneg = m4.nxneg;
    m5_next.nyneg = m4.nyneg;
    m5_next.nxm   = m4.nxm;
    m5_next.nym   = m4.nym;
    m5_next.rata  = m4.rata;
    m5_next.ratb  = m4.ratb;
    m5_next.j     = pr_j[SW+EW:RB];
  end

  always_comb begin
    pr_a = (JW+QW)'(m5.j) * (JW+QW)'(m5.rata);
    pr_b = (JW+QW)'(m5.j) * (JW+QW)'(m5.ratb);
    m6_next.pax   = m5.pax;
    m6_next.pay   = m5.pay;
    m6_next.pbx   = m5.pbx;
    m6_next.pby   = m5.pby;
    m6_next.avx   = m5.avx;
    m6_next.avy   = m5.avy;
    m6_next.bvx   = m5.bvx;
    m6_next.bvy   = m5.bvy;
    m6_next.ov    = m5.ov;
    m6_next.imp   = m5.imp;
    m6_next.nxneg = m5.nxneg;
    m6_next.nyneg = m5.nyneg;
    m6_next.nxm   = m5.nxm;
    m6_next.nym   = m5.nym;
    m6_next.dva   = pr_a[JW+QW-1:F];
    m6_next.dvb   = pr_b[JW+QW-1:F];
  end

  always_comb begin
    pr_vax = (DW+QW)'(m6.dva) * (DW+QW)'(m6.nxm);
    pr_vay = (DW+QW)'(m6.dva) * (DW+QW)'(m6.nym);
    pr_vbx = (DW+QW)'(m6.dvb) * (DW+QW)'(m6.nxm);
    pr_vby = (DW+QW)'(m6.dvb) * (DW+QW)'(m6.nym);
    m7_next.pax   = m6.pax;
    m7_next.pay   = m6.pay;
    m7_next.pbx   = m6.pbx;
    m7_next.pby   = m6.pby;
    m7_next.avx   = m6.avx;
    m7_next.avy   = m6.avy;
    m7_next.bvx   = m6.bvx;
    m7_next.bvy   = m6.bvy;
    m7_next.ov    = m6.ov;
    m7_next.imp   = m6.imp;
    m7_next.nxneg = m6.nxneg;
    m7_next.nyneg = m6.nyneg;
    m7_next.dax   = pr_vax[DW+QW-1:F];
    m7_next.day   = pr_vay[DW+QW-1:F];
    m7_next.dbx   = pr_vbx[DW+QW-1:F];
    m7_next.dby   = pr_vby[DW+QW-1:F];
  end

  always_comb begin
    o_next.pax = m7.pax;
    o_next.pay = m7.pay;
    o_next.pbx = m7.pbx;
    o_next.pby = m7.pby;
    o_next.vax = m7.imp ? apply_sat(m7.avx, m7.nxneg, MAGW'(m7.dax), 1'b0) : m7.avx;
    o_next.vay = m7.imp ? apply_sat(m7.avy, m7.nyneg, MAGW'(m7.day), 1'b0) : m7.avy;
    o_next.vbx = m7.imp ? apply_sat(m7.bvx, m7.nxneg, MAGW'(m7.dbx), 1'b1) : m7.bvx;
    o_next.vby = m7.imp ? apply_sat(m7.bvy, m7.nyneg, MAGW'(m7.dby), 1'b1) : m7.bvy;
    o_next.ov  = m7.ov;
    o_next.imp = m7.imp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, out_v} <= '0;
    end else if (adv) begin
      {v1, v2, v3, v4, v5, v6, v7, out_v} <= {in_v, v1, v2, v3, v4, v5, v6, v7};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1    <= m1_next;
      m2    <= m2_next;
      m3    <= m3_next;
      m4    <= m4_next;
      m5    <= m5_next;
      m6    <= m6_next;
      m7    <= m7_next;
      out_d <= o_next;
    end
  end

  a_no_ov: assert property (@(posedge clk) disable iff (rst)
      (v7 && adv && !m7.ov) |=> (out_v && !out_d.ov && !out_d.imp))
    else $error("separation-free item gained an impulse");

endmodule

`default_nettype wire

FILE: hdl/circle_pair_impulse_resolver.sv
// ============================================================================
// circle_pair_impulse_resolver
// Overlap test, separation and restitution impulse for one circle pair.
// ============================================================================
//  channel   handshake             payload
//  input     push / full           a_*, b_* position, velocity, radius, mass
//  result    pop / empty           new_* positions and velocities, flags
//  config    cfg_valid / cfg_ready cfg_data: restitution, Q1.16
//
//  One item per cycle enters and leaves while results are taken and the queue
//  has room; with an empty queue a result reaches the ports through two front
//  stages, one queue slot, 32 square root stages, 17 divider stages, seven
//  arithmetic stages and the result register.
//  Reset clears all valid state and sets restitution to 0.8.
//  A result not taken holds the whole back pipeline; the front keeps taking
//  items until its four-entry queue fills, then raises full.
// ============================================================================
`default_nettype none

module circle_pair_impulse_resolver import cpir_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] a_pos_x,
  input  logic signed [31:0] a_pos_y,
  input  logic signed [31:0] a_vel_x,
  input  logic signed [31:0] a_vel_y,
  input  logic        [30:0] a_radius,
  input  logic        [30:0] a_mass,
  input  logic signed [31:0] b_pos_x,
  input  logic signed [31:0] b_pos_y,
  input  logic signed [31:0] b_vel_x,
  input  logic signed [31:0] b_vel_y,
  input  logic        [30:0] b_radius,
  input  logic        [30:0] b_mass,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] new_a_pos_x,
  output logic signed [31:0] new_a_pos_y,
  output logic signed [31:0] new_a_vel_x,
  output logic signed [31:0] new_a_vel_y,
  output logic signed [31:0] new_b_pos_x,
  output logic signed [31:0] new_b_pos_y,
  output logic signed [31:0] new_b_vel_x,
  output logic signed [31:0] new_b_vel_y,
  output logic               overlapped,
  output logic               impulse_applied,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [EW-1:0]      cfg_data
);

  logic [EW-1:0] rest;
  logic          wr, rd, adv, sv_v, out_v;
  fr_t           wr_d, rd_d;
  q_stat_t       qs;
  sv_t           sv_d;
  out_t          od;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) rest <= RES_RESET;
    else if (cfg_valid && cfg_ready) rest <= cfg_data;
  end

  assign full  = qs.full;
  assign empty = !out_v;
  assign adv   = !out_v || pop;
  assign rd    = adv && qs.nempty;

  cpir_front u_front (
    .clk, .rst, .push, .q_full(qs.full),
    .a_pos_x, .a_pos_y, .a_vel_x, .a_vel_y, .a_radius, .a_mass,
    .b_pos_x, .b_pos_y, .b_vel_x, .b_vel_y, .b_radius, .b_mass,
    .wr, .wr_d
  );

  cpir_queue u_queue (
    .clk, .rst, .wr, .wr_d, .rd, .rd_d, .st(qs)
  );

  cpir_solve u_solve (
    .clk, .rst, .adv, .in_v(rd), .in_d(rd_d), .out_v(sv_v), .out_d(sv_d)
  );

  cpir_post u_post (
    .clk, .rst, .adv, .rest, .in_v(sv_v), .in_d(sv_d), .out_v, .out_d(od)
  );

  assign new_a_pos_x     = od.pax;
  assign new_a_pos_y     = od.pay;
  assign new_a_vel_x     = od.vax;
  assign new_a_vel_y     = od.vay;
  assign new_b_pos_x     = od.pbx;
  assign new_b_pos_y     = od.pby;
  assign new_b_vel_x     = od.vbx;
  assign new_b_vel_y     = od.vby;
  assign overlapped      = od.ov;
  assign impulse_applied = od.imp;

  a_imp_ov: assert property (@(posedge clk) disable iff (rst)
      (!empty && impulse_applied) |-> overlapped)
    else $error("impulse without overlap");
  a_rst: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("not idle after reset");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the circle pair impulse resolver: random and
// directed circle pairs through the queue ports, results compared per field
// against an integer predictor, restitution swept between phases.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tb_top import cpir_pkg::*; ();

  typedef struct {
    logic signed [31:0] ax, ay, avx, avy;
    logic [30:0]        ra, ma;
    logic signed [31:0] bx, by, bvx, bvy;
    logic [30:0]        rb, mb;
  } pair_t;

  typedef struct {
    logic signed [31:0] v [8];
    logic               ov, imp;
  } res_t;

  localparam longint CYCLE_LIMIT = 400000;

  logic clk, rst;
  logic push, full, empty, pop;
  logic signed [31:0] a_pos_x, a_pos_y, a_vel_x, a_vel_y;
  logic signed [31:0] b_pos_x, b_pos_y, b_vel_x, b_vel_y;
  logic [30:0] a_radius, a_mass, b_radius, b_mass;
  logic signed [31:0] new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y;
  logic signed [31:0] new_b_pos_x, new_b_pos_y, new_b_vel_x, new_b_vel_y;
  logic overlapped, impulse_applied;
  logic cfg_valid, cfg_ready;
  logic [EW-1:0] cfg_data;

  circle_pair_impulse_resolver u_dut (.*);

  pair_t  pending [$];
  res_t   expected [$];
  logic [EW-1:0] bounce;
  int     errors = 0;
  longint cycles = 0;
  int     burst_left = 0, gap_left = 0;
  int     stall_phase = 0;
  bit     stall_on = 1;

  function automatic void add_pending(input pair_t p);
    pending.insert(pending.size(), p);
  endfunction

  function automatic void add_expected(input res_t r);
    expected.insert(expected.size(), r);
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] shift_by(input logic signed [127:0] base,
                                                  input logic signed [127:0] n,
                                                  input logic [127:0] m,
                                                  input bit add);
    logic signed [127:0] d;
    d = $signed(m);
    if (n < 0) d = -d;
    return add ? base + d : base - d;
  endfunction

  function automatic res_t resolve_pair(input pair_t p);
    res_t r;
    logic signed [127:0] dx, dy, nx, ny, vn;
    logic signed [127:0] k [8];
    logic [127:0] dxm, dym, lo, rsum, sep, pen, tot, rat_a, rat_b, nxm, nym;
    logic [127:0] px, py, e, s, j, dva, dvb;
    k[0] = p.ax; k[1] = p.ay; k[2] = p.avx; k[3] = p.avy;
    k[4] = p.bx; k[5] = p.by; k[6] = p.bvx; k[7] = p.bvy;
    r.ov = 0; r.imp = 0;
    dx = k[4] - k[0]; dy = k[5] - k[1];
    dxm = dx < 0 ? -dx : dx; dym = dy < 0 ? -dy : dy;
    lo = dxm * dxm + dym * dym;
    rsum = 128'(p.ra) + 128'(p.rb);
    if (lo < 128'd1 << 64 && lo < rsum * rsum) begin
      sep = isqrt(lo[63:0]);
      r.ov = 1;
      if (sep == 0) begin
        nx = 128'sd1 << 16; ny = 0;
      end else begin
        nx = $signed((dxm << 16) / sep); ny = $signed((dym << 16) / sep);
        if (dx < 0) nx = -nx;
        if (dy < 0) ny = -ny;
      end
      nxm = nx < 0 ? -nx : nx; nym = ny < 0 ? -ny : ny;
      pen = rsum - sep;
      tot = 128'(p.ma) + 128'(p.mb);
      if (tot == 0) begin
        rat_a = 128'd1 << 15; rat_b = rat_a;
      end else begin
        rat_a = (128'(p.mb) << 16) / tot; rat_b = (128'(p.ma) << 16) / tot;
      end
      px = (nxm * pen) >> 16; py = (nym * pen) >> 16;
      k[0] = shift_by(k[0], nx, (px * rat_a) >> 16, 0);
      k[1] = shift_by(k[1], ny, (py * rat_a) >> 16, 0);
      k[4] = shift_by(k[4], nx, (px * rat_b) >> 16, 1);
      k[5] = shift_by(k[5], ny, (py * rat_b) >> 16, 1);
      vn = (k[6] - k[2]) * nx + (k[7] - k[3]) * ny;
      if (vn <= 0) begin
        e = bounce > RES_ONE ? 128'(RES_ONE) : 128'(bounce);
        s = (-vn) >> 16;
        j = (s * (128'd65536 + e)) >> 16;
        dva = (j * rat_a) >> 16; dvb = (j * rat_b) >> 16;
        r.imp = 1;
        k[2] = shift_by(k[2], nx, (dva * nxm) >> 16, 0);
        k[3] = shift_by(k[3], ny, (dva * nym) >> 16, 0);
        k[6] = shift_by(k[6], nx, (dvb * nxm) >> 16, 1);
        k[7] = shift_by(k[7], ny, (dvb * nym) >> 16, 1);
      end
    end
    // output order: a pos, a vel, b pos, b vel
    foreach (k[i]) r.v[i] = clamp32(k[i]);
    return r;
  endfunction

  function automatic logic [31:0] rnd_word(input int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int m;
    m = $urandom_range(0, 9);
    m = (m == 0) ? 0 : (m < 3 ? 1 : 2);
    p.ax = rnd_word(m); p.ay = rnd_word(m);
    p.avx = rnd_word(m); p.avy = rnd_word(m);
    p.ra = m == 0 ? 31'($urandom()) : 31'($urandom_range(0, 32'h0008_0000));
    p.ma = $urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(1, 32'h0010_0000));
    if ($urandom_range(0, 3) != 0) begin
      p.bx = p.ax + (rnd_word(2) >>> 1); p.by = p.ay + (rnd_word(2) >>> 1);
    end else begin
      p.bx = rnd_word(m); p.by = rnd_word(m);
    end
    if ($urandom_range(0, 7) == 0) begin
      p.bx = p.ax; p.by = p.ay;
    end
    p.bvx = rnd_word(m); p.bvy = rnd_word(m);
    p.rb = m == 0 ? 31'($urandom()) : 31'($urandom_range(0, 32'h0008_0000));
    p.mb = $urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(1, 32'h0010_0000));
    return p;
  endfunction

  function automatic pair_t make_pair(input logic signed [31:0] ax, ay, avx, avy,
                                      input logic [30:0] ra, ma,
                                      input logic signed [31:0] bx, by, bvx, bvy,
                                      input logic [30:0] rb, mb);
    pair_t p;
    p.ax = ax; p.ay = ay; p.avx = avx; p.avy = avy; p.ra = ra; p.ma = ma;
    p.bx = bx; p.by = by; p.bvx = bvx; p.bvy = bvy; p.rb = rb; p.mb = mb;
    return p;
  endfunction

  // sender: bursts and gaps
  always @(posedge clk) begin
    pair_t p;
    cycles <= cycles + 1;
    if (rst) begin
      push <= 0;
    end else begin
      if (push && !full) begin
        void'(pending.pop_front());
        add_expected(resolve_pair(make_pair(a_pos_x, a_pos_y, a_vel_x, a_vel_y,
                                            a_radius, a_mass, b_pos_x, b_pos_y,
                                            b_vel_x, b_vel_y, b_radius, b_mass)));
      end
      if (push && full) begin
        // hold the offered item
      end else begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
        end
        if (pending.size() > 0 && burst_left > 0) begin
          p = pending[0];
          burst_left--;
          push <= 1;
          a_pos_x <= p.ax; a_pos_y <= p.ay; a_vel_x <= p.avx; a_vel_y <= p.avy;
          a_radius <= p.ra; a_mass <= p.ma;
          b_pos_x <= p.bx; b_pos_y <= p.by; b_vel_x <= p.bvx; b_vel_y <= p.bvy;
          b_radius <= p.rb; b_mass <= p.mb;
        end else begin
          if (gap_left > 0) gap_left--;
          push <= 0;
        end
      end
    end
  end

  // receiver: stall pattern and checks
  always @(posedge clk) begin
    res_t e;
    logic signed [31:0] got [8];
    if (rst) begin
      pop <= 0;
    end else begin
      if (pop && !empty) begin
        got = '{new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y,
                new_b_pos_x, new_b_pos_y, new_b_vel_x, new_b_vel_y};
        if (expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected result item", $time);
        end else begin
          e = expected.pop_front();
          foreach (got[i])
            if (got[i] !== e.v[i]) begin
              errors++;
              $display("%0t: field %0d expected %0d actual %0d", $time, i, e.v[i], got[i]);
            end
          if (overlapped !== e.ov) begin
            errors++;
            $display("%0t: overlapped expected %b actual %b", $time, e.ov, overlapped);
          end
          if (impulse_applied !== e.imp) begin
            errors++;
            $display("%0t: impulse_applied expected %b actual %b", $time, e.imp,
                     impulse_applied);
          end
        end
      end
      stall_phase = (stall_phase + 1) % 97;
      if (stall_phase == 0) stall_on = ~stall_on;
      pop <= stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
    end
  end

  always @(posedge clk)
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end

  task automatic write_bounce(input logic [EW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    bounce = val;
  endtask

  task automatic drain();
    while (pending.size() != 0 || push) @(posedge clk);
    while (expected.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    logic [EW-1:0] settings [4];
    settings = '{17'd0, 17'h10000, 17'h1FFFF, 17'd32768};
    rst = 1; push = 0; pop = 0; cfg_valid = 0; cfg_data = 0;
    {a_pos_x, a_pos_y, a_vel_x, a_vel_y, b_pos_x, b_pos_y, b_vel_x, b_vel_y} = '0;
    {a_radius, a_mass, b_radius, b_mass} = '0;
    bounce = RES_RESET;
    repeat (5) @(posedge clk);
    rst <= 0;

    // directed: default restitution
    add_pending(make_pair(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1));
    add_pending(make_pair(0, 0, 32'h10000, 0, 32'h10000, 32'h10000,
                          0, 0, 0, 0, 32'h10000, 32'h10000));
    add_pending(make_pair(0, 0, 32'h10000, 0, 32'h10000, 32'h10000,
                          32'h18000, 0, -32'sh10000, 0, 32'h10000, 32'h30000));
    add_pending(make_pair(0, 0, -32'sh10000, 0, 32'h10000, 32'h10000,
                          32'h18000, 0, 32'h10000, 0, 32'h10000, 32'h10000));
    add_pending(make_pair(0, 0, 0, 0, 32'h10000, 32'h10000,
                          32'h50000, 32'h50000, 0, 0, 32'h10000, 32'h10000));
    add_pending(make_pair(32'sh80000000, 32'sh80000000, 32'sh80000000,
                          32'sh80000000, 31'h7fffffff, 31'h7fffffff,
                          32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                          32'sh7fffffff, 31'h7fffffff, 31'h7fffffff));
    add_pending(make_pair(32'sh7fff0000, 32'sh7fff0000, 32'sh7fffffff,
                          32'sh7fffffff, 31'h7fffffff, 1,
                          32'sh7fff0000, 32'sh7fff0000, 32'sh80000000,
                          32'sh80000000, 31'h7fffffff, 31'h7fffffff));
    add_pending(make_pair(-32'sh8000, 32'sh8000, 32'sh40000, -32'sh40000,
                          32'h20000, 0, 32'sh8000, -32'sh8000, -32'sh40000,
                          32'sh40000, 32'h20000, 0));
    add_pending(make_pair(32'sh7fffffff, 0, 0, 0, 31'h40000000, 1,
                          32'sh80000000, 0, 0, 0, 31'h40000000, 1));
    add_pending(make_pair(-1, -1, -1, -1, 31'h7fffffff, 31'h7fffffff,
                          -1, -1, -1, -1, 0, 1));
    drain();
    foreach (settings[s]) begin
      write_bounce(settings[s]);
      if (s == 1)
        add_pending(make_pair(0, 0, 32'h10000, 0, 32'h10000, 32'h10000,
                              32'h18000, 0, -32'sh10000, 0, 32'h10000, 32'h10000));
      repeat (360) add_pending(random_pair());
      drain();
    end
    write_bounce($urandom_range(0, 17'h1FFFF));
    repeat (20) add_pending(random_pair());
    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: circle_pair_impulse_resolver.f
hdl/cpir_pkg.sv
hdl/cpir_front.sv
hdl/cpir_queue.sv
hdl/cpir_solve.sv
hdl/cpir_post.sv
hdl/circle_pair_impulse_resolver.sv
bench/tb_top.sv
